@@ rtl/pcw_pkg.sv @@
// ----------------------------------------------------------------------------
// pcw_pkg
// Shared types, constants and the header table of the configuration window.
// ----------------------------------------------------------------------------
package pcw_pkg;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_RSVD = 2'd3
  } size_e;

  typedef struct packed {
    logic        action;
    logic [2:0]  byte_offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
  } access_t;

  localparam logic [2:0]  OffAddr      = 3'd0;
  localparam logic [2:0]  OffData      = 3'd4;

  localparam logic [31:0] SelectMask   = 32'h7FFF_FF00;
  localparam logic [31:0] DeviceSelect = 32'h0000_7800;
  localparam logic [31:0] AllOnes      = 32'hFFFF_FFFF;

  localparam logic [5:0]  IdxBar0      = 6'd4;
  localparam logic [5:0]  IdxBar1      = 6'd5;

  localparam logic [31:0] Bar0Reset    = 32'hCA00_0008;
  localparam logic [31:0] Bar1Reset    = 32'hC800_0000;
  localparam logic [31:0] Bar0Mask     = 32'hFF00_0000;
  localparam logic [31:0] Bar1Mask     = 32'hFFE0_0000;
  localparam logic [31:0] Bar0Flags    = 32'h0000_0008;
  localparam logic        PresentReset = 1'b1;

  function automatic logic [31:0] header_word(input logic [5:0]  idx,
                                              input logic [31:0] bar0,
                                              input logic [31:0] bar1);
    logic [31:0] w;
    unique case (idx)
      6'd0:    w = 32'h0501_126F;
      6'd1:    w = 32'h0200_0007;
      6'd2:    w = 32'h0300_0000;
      IdxBar0: w = bar0;
      IdxBar1: w = bar1;
      6'd11:   w = 32'h0501_126F;
      6'd15:   w = 32'h0000_0100;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/pci_config_cycle_window_unit.sv @@
// ----------------------------------------------------------------------------
// pci_config_cycle_window_unit
// Eight-byte configuration window: address latch at offset 0, data port at
// offset 4 into the type-0 header of one display device.
//
// One access item enters on the input channel (valid/stall) with action,
// byte offset, size and write data. Each item gives exactly one result item
// on the output channel carrying read_data (zero for writes).
// The item is first captured in an input register; it is executed against
// the window state when it moves to the result register. One item per
// cycle is sustained while the receiver does not stall, set by the single
// decode pass between the two registers. When the receiver stalls, the
// result register holds and the input register fills; the input stall
// then rises until the output drains. Reset empties both registers, clears
// the address latch, restores the bar words and marks the device present.
// device_present is written through cfg_we_i / cfg_wdata_i; the user must
// do so only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module pci_config_cycle_window_unit
  import pcw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [2:0]  byte_offset_i,
  input  logic [1:0]  access_size_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o
);

  logic        in_valid_q;
  access_t     acc_q;
  logic        out_valid_q;
  logic [31:0] rdata_q;
  logic [31:0] rdata;
  logic        advance;
  logic        accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  pcw_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .exec_i      (advance),
    .acc_i       (acc_q),
    .read_data_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q.action      <= action_i;
      acc_q.byte_offset <= byte_offset_i;
      acc_q.access_size <= access_size_i;
      acc_q.write_data  <= write_data_i;
    end
    if (advance) begin
      rdata_q <= rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;

endmodule

@@ rtl/pcw_regs.sv @@
// ----------------------------------------------------------------------------
// pcw_regs
// Address latch, bar registers and read decode for one window access.
// ----------------------------------------------------------------------------
module pcw_regs
  import pcw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        exec_i,
  input  access_t     acc_i,
  output logic [31:0] read_data_o
);

  logic        present_q;
  logic [31:0] addr_q, addr_d;
  logic [31:0] bar0_q, bar0_d;
  logic [31:0] bar1_q, bar1_d;

  logic        selected;
  logic [5:0]  idx;
  logic [31:0] hdr;
  logic [31:0] lane_word;
  logic [31:0] full_word;
  logic [31:0] rdata;
  logic        is_word;

  assign selected = present_q && ((addr_q & SelectMask) == DeviceSelect);
  assign idx      = addr_q[7:2];
  assign hdr      = selected ? header_word(idx, bar0_q, bar1_q) : AllOnes;
  assign is_word  = acc_i.access_size[1];

  // word for byte and half lanes: offset with low bits cleared
  assign lane_word = acc_i.byte_offset[2] ? hdr : addr_q;

  always_comb begin
    if (acc_i.byte_offset == OffAddr) begin
      full_word = addr_q;
    end else if (acc_i.byte_offset == OffData) begin
      full_word = hdr;
    end else begin
      full_word = AllOnes;
    end
  end

  always_comb begin
    rdata = '0;
    if (acc_i.action == ACT_READ) begin
      case (acc_i.access_size)
        SIZE_BYTE: rdata = {24'd0, lane_word[{acc_i.byte_offset[1:0], 3'd0} +: 8]};
        SIZE_HALF: rdata = {16'd0, lane_word[{acc_i.byte_offset[1], 4'd0} +: 16]};
        default:   rdata = full_word;
      endcase
    end
  end

  always_comb begin
    addr_d = addr_q;
    bar0_d = bar0_q;
    bar1_d = bar1_q;
    if (exec_i && acc_i.action == ACT_WRITE && is_word) begin
      if (acc_i.byte_offset == OffAddr) begin
        addr_d = acc_i.write_data;
      end else if (acc_i.byte_offset == OffData && selected) begin
        if (idx == IdxBar0) begin
          bar0_d = (acc_i.write_data == AllOnes) ? Bar0Mask
                 : ((acc_i.write_data & Bar0Mask) | Bar0Flags);
        end else if (idx == IdxBar1) begin
          bar1_d = (acc_i.write_data == AllOnes) ? Bar1Mask
                 : (acc_i.write_data & Bar1Mask);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= PresentReset;
      addr_q    <= '0;
      bar0_q    <= Bar0Reset;
      bar1_q    <= Bar1Reset;
    end else begin
      if (cfg_we_i) begin
        present_q <= cfg_wdata_i;
      end
      addr_q <= addr_d;
      bar0_q <= bar0_d;
      bar1_q <= bar1_d;
    end
  end

  assign read_data_o = rdata;

endmodule

@@ sim/pci_config_cycle_window_unit_tb.sv @@
// ----------------------------------------------------------------------------
// pci_config_cycle_window_unit_tb
// Drives access items into the configuration window and checks every read_data
// item against a cycle-free model of the address latch, the header and the
// bar sizing. A short table of directed accesses comes first, then random
// phases with device_present set both ways, with random idling on both sides.
// ----------------------------------------------------------------------------
module pci_config_cycle_window_unit_tb;
  import pcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandPhases   = 6;
  localparam int unsigned PhaseItems   = 275;
  localparam int unsigned StuckLimit   = 2000;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned DrainCycles  = 8;

  typedef struct packed {
    action_e     act;
    logic [2:0]  off;
    size_e       sz;
    logic [31:0] wd;
    logic        typed;
    logic [31:0] want;
  } access_row_t;

  localparam int unsigned DirRows = 25;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = 1'b0;
  logic [2:0]  byte_offset_i = '0;
  logic [1:0]  access_size_i = '0;
  logic [31:0] write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_data_o;

  logic [31:0] addr_latch;
  logic [31:0] bar0_word;
  logic [31:0] bar1_word;
  logic        present;

  logic [31:0] pending_read_data [$];
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles = 0;
  bit          calm = 1'b0;

  access_row_t dir_table [DirRows] = '{
    '{ACT_READ,  3'd0, SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ACT_READ,  3'd4, SIZE_WORD, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{ACT_WRITE, 3'd0, SIZE_WORD, 32'h0000_7800, 1'b1, 32'h0000_0000},
    '{ACT_READ,  3'd4, SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0501_126F},
    '{ACT_READ,  3'd5, SIZE_BYTE, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_READ,  3'd6, SIZE_HALF, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_READ,  3'd4, SIZE_RSVD, 32'h0000_0000, 1'b1, 32'h0501_126F},
    '{ACT_READ,  3'd1, SIZE_WORD, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{ACT_WRITE, 3'd0, SIZE_WORD, 32'h0000_7810, 1'b1, 32'h0000_0000},
    '{ACT_READ,  3'd4, SIZE_WORD, 32'h0000_0000, 1'b1, 32'hCA00_0008},
    '{ACT_WRITE, 3'd4, SIZE_WORD, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{ACT_READ,  3'd4, SIZE_WORD, 32'h0000_0000, 1'b1, 32'hFF00_0000},
    '{ACT_WRITE, 3'd4, SIZE_HALF, 32'h1234_5678, 1'b1, 32'h0000_0000},
    '{ACT_WRITE, 3'd6, SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ACT_WRITE, 3'd4, SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ACT_READ,  3'd4, SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0000_0008},
    '{ACT_WRITE, 3'd0, SIZE_WORD, 32'h8000_7814, 1'b1, 32'h0000_0000},
    '{ACT_READ,  3'd4, SIZE_WORD, 32'h0000_0000, 1'b1, 32'hC800_0000},
    '{ACT_WRITE, 3'd4, SIZE_WORD, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{ACT_READ,  3'd4, SIZE_WORD, 32'h0000_0000, 1'b1, 32'hFFE0_0000},
    '{ACT_WRITE, 3'd4, SIZE_WORD, 32'hABCD_EF01, 1'b1, 32'h0000_0000},
    '{ACT_READ,  3'd7, SIZE_BYTE, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_WRITE, 3'd0, SIZE_WORD, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{ACT_READ,  3'd3, SIZE_BYTE, 32'h0000_0000, 1'b1, 32'h0000_00FF},
    '{ACT_WRITE, 3'd0, SIZE_WORD, 32'h0000_783C, 1'b1, 32'h0000_0000}
  };

  pci_config_cycle_window_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .byte_offset_i (byte_offset_i),
    .access_size_i (access_size_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic device_hit();
    return present && ((addr_latch & SelectMask) == DeviceSelect);
  endfunction

  function automatic logic [31:0] header_entry(input logic [5:0] idx);
    logic [31:0] w;
    w = '0;
    if (idx == IdxBar0) w = bar0_word;
    else if (idx == IdxBar1) w = bar1_word;
    else if (idx == 6'd0 || idx == 6'd11) w = 32'h0501_126F;
    else if (idx == 6'd1) w = 32'h0200_0007;
    else if (idx == 6'd2) w = 32'h0300_0000;
    else if (idx == 6'd15) w = 32'h0000_0100;
    return w;
  endfunction

  function automatic logic [31:0] window_word(input logic [2:0] off);
    logic [31:0] w;
    w = AllOnes;
    if (off == OffAddr) w = addr_latch;
    else if (off == OffData && device_hit()) w = header_entry(addr_latch[7:2]);
    return w;
  endfunction

  // applies one access to the model state and gives its read_data
  function automatic logic [31:0] predict_read_data(input action_e act, input logic [2:0] off,
                                                    input size_e sz, input logic [31:0] wd);
    logic [31:0] w;
    logic [31:0] r;
    r = '0;
    if (act == ACT_WRITE) begin
      if (sz == SIZE_WORD || sz == SIZE_RSVD) begin
        if (off == OffAddr) begin
          addr_latch = wd;
        end else if (off == OffData && device_hit()) begin
          if (addr_latch[7:2] == IdxBar0)
            bar0_word = (wd == AllOnes) ? Bar0Mask : ((wd & Bar0Mask) | Bar0Flags);
          else if (addr_latch[7:2] == IdxBar1)
            bar1_word = (wd == AllOnes) ? Bar1Mask : (wd & Bar1Mask);
        end
      end
    end else if (sz == SIZE_BYTE) begin
      w = window_word({off[2], 2'b00});
      r = {24'd0, w[8 * off[1:0] +: 8]};
    end else if (sz == SIZE_HALF) begin
      w = window_word({off[2], 2'b00});
      r = {16'd0, w[16 * off[1] +: 16]};
    end else begin
      r = window_word(off);
    end
    return r;
  endfunction

  task automatic send_access(input action_e act, input logic [2:0] off, input size_e sz,
                             input logic [31:0] wd, input logic typed, input logic [31:0] want);
    logic [31:0] predicted;
    if (!calm && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    action_i      <= act;
    byte_offset_i <= off;
    access_size_i <= sz;
    write_data_i  <= wd;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_read_data(act, off, sz, wd);
    pending_read_data.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_read_data.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_present(input logic value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    present = value;
  endtask

  task automatic random_access();
    logic [5:0]  idx;
    logic [31:0] wd;
    int unsigned pick;
    pick = $urandom_range(99);
    wd = $urandom();
    if (pick < 35) begin
      // address write, mostly aimed at the device
      if ($urandom_range(99) < 70) begin
        case ($urandom_range(0, 9))
          0: idx = 6'd0;
          1: idx = 6'd1;
          2: idx = 6'd2;
          3: idx = 6'd3;
          4, 5: idx = IdxBar0;
          6, 7: idx = IdxBar1;
          8: idx = 6'd15;
          default: idx = 6'($urandom_range(0, 63));
        endcase
        wd = {wd[31], DeviceSelect[30:8], idx, wd[1:0]};
      end
      send_access(ACT_WRITE, OffAddr, SIZE_WORD, wd, 1'b0, '0);
    end else if (pick < 70) begin
      // data port traffic
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(99) < 30) wd = AllOnes;
        send_access(ACT_WRITE, OffData, size_e'($urandom_range(2, 3)), wd, 1'b0, '0);
      end else begin
        send_access(ACT_READ, OffData | 3'($urandom_range(0, 3)),
                    size_e'($urandom_range(0, 3)), wd, 1'b0, '0);
      end
    end else begin
      send_access(action_e'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  size_e'($urandom_range(0, 3)), wd, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 13);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_read_data.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected item: read_data %h", read_data_o);
      end else begin
        if (read_data_o !== pending_read_data[0]) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("read_data mismatch: expected %h actual %h",
                     pending_read_data[0], read_data_o);
        end
        void'(pending_read_data.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    addr_latch = '0;
    bar0_word  = Bar0Reset;
    bar1_word  = Bar1Reset;
    present    = PresentReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++)
      send_access(dir_table[i].act, dir_table[i].off, dir_table[i].sz, dir_table[i].wd,
                  dir_table[i].typed, dir_table[i].want);
    drain();

    for (int p = 0; p < RandPhases; p++) begin
      write_present(p[0]);
      calm = (p == 3);
      for (int n = 0; n < PhaseItems; n++) random_access();
      drain();
    end
    calm = 1'b0;

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_read_data.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/pcw_pkg.sv
rtl/pcw_regs.sv
rtl/pci_config_cycle_window_unit.sv
sim/pci_config_cycle_window_unit_tb.sv
